FILE: rtl/sskth_pkg.sv
// ----------------------------------------------------------------------------
// Sort store package
// Shared constants, word types, command and result codes, and the state
// encoding for the sort store with k-th smallest selection.
// ----------------------------------------------------------------------------
package sskth_pkg;

  // Store geometry.
  localparam int unsigned DEPTH      = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned RANK_W     = 5;

  // The store starts out holding the values one to seven.
  localparam int unsigned INIT_COUNT = 7;
  localparam int unsigned INIT_AW    = $clog2(INIT_COUNT);

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(4);

  // Input commands.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_DUMP  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_RANK = 2'd0;
  localparam logic [1:0] KIND_LIST = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } out_word_t;

  // One read and one write on the store per cycle.
  typedef struct packed {
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_STEP,
    ST_TAIL,
    ST_RANK,
    ST_ERR,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/sskth_ram.sv
// ----------------------------------------------------------------------------
// Sort store RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sskth_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/sskth_store.sv
// ----------------------------------------------------------------------------
// Sort store
// Wraps the RAM with the reset contents: entries below the initial count read
// as their index plus one until they are first written.
// ----------------------------------------------------------------------------
module sskth_store (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  sskth_pkg::mem_req_t                      req_i,
  output logic signed [sskth_pkg::DATA_W-1:0]      rd_data_o
);

  logic [sskth_pkg::INIT_COUNT-1:0] written_q;
  logic [sskth_pkg::INIT_COUNT-1:0] written_d;
  logic                             init_hit_q;
  logic                             init_hit_d;
  logic [sskth_pkg::DATA_W-1:0]     init_val_q;
  logic [sskth_pkg::DATA_W-1:0]     init_val_d;
  logic [sskth_pkg::DATA_W-1:0]     ram_rdata;

  sskth_ram #(
    .Depth (sskth_pkg::DEPTH),
    .Width (sskth_pkg::DATA_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.wr_addr),
    .wr_data_i (req_i.wr_data),
    .rd_en_i   (req_i.rd_en),
    .rd_addr_i (req_i.rd_addr),
    .rd_data_o (ram_rdata)
  );

  // Track which of the initial entries have been overwritten.
  always_comb begin
    written_d = written_q;
    if (req_i.wr_en &&
        ({1'b0, req_i.wr_addr} < (sskth_pkg::ADDR_W + 1)'(sskth_pkg::INIT_COUNT))) begin
      written_d[req_i.wr_addr[sskth_pkg::INIT_AW-1:0]] = 1'b1;
    end
  end

  // Decide at read time whether the initial value stands in for the RAM.
  always_comb begin
    init_hit_d = init_hit_q;
    init_val_d = init_val_q;
    if (req_i.rd_en) begin
      init_hit_d = 1'b0;
      if ({1'b0, req_i.rd_addr} < (sskth_pkg::ADDR_W + 1)'(sskth_pkg::INIT_COUNT)) begin
        init_hit_d = !written_q[req_i.rd_addr[sskth_pkg::INIT_AW-1:0]];
      end
      init_val_d = sskth_pkg::DATA_W'(req_i.rd_addr) + sskth_pkg::DATA_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      init_hit_q <= 1'b0;
    end else begin
      written_q  <= written_d;
      init_hit_q <= init_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_val_q <= init_val_d;
  end

  assign rd_data_o = init_hit_q ? $signed(init_val_q) : $signed(ram_rdata);

endmodule

FILE: rtl/sort_store_kth_select_top.sv
// ----------------------------------------------------------------------------
// Sort store with k-th smallest selection
// Usage: a push word appends a signed value to the store, which holds one to
// seven after reset. A query word sorts the store in ascending order, returns
// the value at the configured rank (or an error word when the rank is at or
// beyond the count) and then the whole sorted list, the final word marked
// last. A dump word sorts and returns the list only. A push to a full store
// returns one error word. The rank register (reset four) is written through
// cfg_we_i and cfg_wdata_i; writing it only while the block is idle is up to
// the user, as the block itself leaves it unchecked.
// Timing: a sort is a bubble sort over the store RAM with one comparator,
// one read and one write per cycle. The list then streams at one word per
// cycle while the output is not stalled, each word passing from the store's
// registered read data into the output register. Only one input word is in
// progress at a time; a new one is taken when the sort and the list are
// finished. A stalled result holds in the output register and the list
// read pauses with it. Reset empties the output and restores the store to
// its initial seven entries.
// ----------------------------------------------------------------------------
module sort_store_kth_select_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sskth_pkg::in_word_t             in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sskth_pkg::out_word_t            out_word_o,
  input  logic                            cfg_we_i,
  input  logic [sskth_pkg::RANK_W-1:0]    cfg_wdata_i
);

  sskth_pkg::state_e state_q, state_d;

  logic [sskth_pkg::CNT_W-1:0]   fill_q, fill_d;
  logic [sskth_pkg::RANK_W-1:0]  rank_q;
  logic [sskth_pkg::ADDR_W-1:0]  lim_q, lim_d;
  logic [sskth_pkg::ADDR_W-1:0]  pos_q, pos_d;
  logic [sskth_pkg::ADDR_W-1:0]  eidx_q, eidx_d;
  logic                          query_q, query_d;
  logic                          emit_rank_q, emit_rank_d;
  logic signed [sskth_pkg::DATA_W-1:0] hold_q, hold_d;

  logic                          out_valid_q, out_valid_d;
  sskth_pkg::out_word_t          out_word_q, out_word_d;

  sskth_pkg::mem_req_t           req;
  logic signed [sskth_pkg::DATA_W-1:0] rd_data;

  logic                          accept;
  logic                          slot_free;
  logic                          swap;

  sskth_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  // Handshake.
  assign in_stall_o = (state_q != sskth_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign swap       = hold_q > rd_data;

  // Sequencer: push, sort passes and list output.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    lim_d       = lim_q;
    pos_d       = pos_q;
    eidx_d      = eidx_q;
    query_d     = query_q;
    emit_rank_d = emit_rank_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    req         = '0;

    unique case (state_q)
      sskth_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_word_i.cmd)
            sskth_pkg::CMD_PUSH: begin
              if (fill_q == sskth_pkg::CNT_W'(sskth_pkg::DEPTH)) begin
                out_valid_d     = 1'b1;
                out_word_d.kind = sskth_pkg::KIND_ERR;
                out_word_d.data = '0;
                out_word_d.last = 1'b1;
              end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = sskth_pkg::ADDR_W'(fill_q);
                req.wr_data = in_word_i.value;
                fill_d      = fill_q + sskth_pkg::CNT_W'(1);
              end
            end
            sskth_pkg::CMD_QUERY, sskth_pkg::CMD_DUMP: begin
              query_d     = (in_word_i.cmd == sskth_pkg::CMD_QUERY);
              lim_d       = sskth_pkg::ADDR_W'(fill_q - sskth_pkg::CNT_W'(1));
              req.rd_en   = 1'b1;
              req.rd_addr = '0;
              state_d     = sskth_pkg::ST_HEAD;
            end
            default: begin
            end
          endcase
        end
      end

      // First element of a pass becomes the carried value.
      sskth_pkg::ST_HEAD: begin
        hold_d      = rd_data;
        req.rd_en   = 1'b1;
        req.rd_addr = sskth_pkg::ADDR_W'(1);
        pos_d       = '0;
        state_d     = sskth_pkg::ST_STEP;
      end

      // Keep the larger value moving; write the smaller one back behind it.
      sskth_pkg::ST_STEP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = pos_q;
        req.wr_data = swap ? rd_data : hold_q;
        hold_d      = swap ? hold_q : rd_data;
        if (pos_q == lim_q - sskth_pkg::ADDR_W'(1)) begin
          state_d = sskth_pkg::ST_TAIL;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = pos_q + sskth_pkg::ADDR_W'(2);
          pos_d       = pos_q + sskth_pkg::ADDR_W'(1);
        end
      end

      // Put the largest value of the pass in place and start the next pass.
      sskth_pkg::ST_TAIL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = lim_q;
        req.wr_data = hold_q;
        if (lim_q == sskth_pkg::ADDR_W'(1)) begin
          state_d = sskth_pkg::ST_RANK;
        end else begin
          lim_d       = lim_q - sskth_pkg::ADDR_W'(1);
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
          state_d     = sskth_pkg::ST_HEAD;
        end
      end

      // Sort done: fetch the rank entry, flag a rank error, or fetch the head of the list.
      sskth_pkg::ST_RANK: begin
        if (query_q) begin
          if ({1'b0, rank_q} < fill_q) begin
            req.rd_en   = 1'b1;
            req.rd_addr = sskth_pkg::ADDR_W'(rank_q);
            emit_rank_d = 1'b1;
            state_d     = sskth_pkg::ST_EMIT;
          end else begin
            state_d = sskth_pkg::ST_ERR;
          end
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
          eidx_d      = '0;
          emit_rank_d = 1'b0;
          state_d     = sskth_pkg::ST_EMIT;
        end
      end

      // Rank out of range: an error word stands in for the rank result.
      sskth_pkg::ST_ERR: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_word_d.kind = sskth_pkg::KIND_ERR;
          out_word_d.data = '0;
          out_word_d.last = 1'b0;
          req.rd_en       = 1'b1;
          req.rd_addr     = '0;
          eidx_d          = '0;
          emit_rank_d     = 1'b0;
          state_d         = sskth_pkg::ST_EMIT;
        end
      end

      // Stream read data into the output register, one word per cycle while the output slot is free.
      sskth_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_word_d.data = rd_data;
          if (emit_rank_q) begin
            out_word_d.kind = sskth_pkg::KIND_RANK;
            out_word_d.last = 1'b0;
            req.rd_en       = 1'b1;
            req.rd_addr     = '0;
            eidx_d          = '0;
            emit_rank_d     = 1'b0;
          end else begin
            out_word_d.kind = sskth_pkg::KIND_LIST;
            if (sskth_pkg::CNT_W'(eidx_q) + sskth_pkg::CNT_W'(1) == fill_q) begin
              out_word_d.last = 1'b1;
              state_d         = sskth_pkg::ST_IDLE;
            end else begin
              out_word_d.last = 1'b0;
              req.rd_en       = 1'b1;
              req.rd_addr     = eidx_q + sskth_pkg::ADDR_W'(1);
              eidx_d          = eidx_q + sskth_pkg::ADDR_W'(1);
            end
          end
        end
      end

      default: begin
        state_d = sskth_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sskth_pkg::ST_IDLE;
      fill_q      <= sskth_pkg::CNT_W'(sskth_pkg::INIT_COUNT);
      rank_q      <= sskth_pkg::RANK_RESET;
      lim_q       <= '0;
      pos_q       <= '0;
      eidx_q      <= '0;
      query_q     <= 1'b0;
      emit_rank_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      lim_q       <= lim_d;
      pos_q       <= pos_d;
      eidx_q      <= eidx_d;
      query_q     <= query_d;
      emit_rank_q <= emit_rank_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
